// ===== rtl/first_fit_partition_allocator_defines.svh =====
// Assertion macros shared by the first-fit allocator RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_DEFINES_SVH

// check gated off while reset is applied
`define FFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds throughout reset
`define FFPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/ffpa_pkg.sv =====
// Package for the first-fit partition allocator: beat types, op and status codes,
// sequencer states and the unit map write control. No dependencies.
package ffpa_pkg;

  localparam int unsigned KB_FIELD_W = 10;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FREED     = 2'd2,
    ST_NOT_START = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_A_PEEK,
    S_A_MARK,
    S_F_FIND,
    S_F_CLEAR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic                  op;
    logic [KB_FIELD_W-1:0] request_kb;
    logic [KB_FIELD_W-1:0] release_addr_kb;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [KB_FIELD_W-1:0] block_addr_kb;
  } out_t;

  typedef struct packed {
    logic used_we;
    logic used_wd;
    logic start_we;
    logic start_wd;
  } map_wr_t;

endpackage

// ===== rtl/first_fit_partition_allocator.sv =====
// First-fit partition allocator over MEMORY_KB / UNIT_KB units (N, 160 by default).
// An allocate sweeps the map to the first free run that fits and then marks the run
// (a full sweep if none fits); a free sweeps to the block start and clears the block.
// One item at a time; a stalled result holds the block. The unit map is swept one
// unit per cycle through its read port.
// Reset: async, active low; then a clearing pass over all units with in_ready_o low.
`include "first_fit_partition_allocator_defines.svh"

module first_fit_partition_allocator #(
  parameter int unsigned MEMORY_KB = 640,
  parameter int unsigned UNIT_KB   = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffpa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ffpa_pkg::out_t out_data_o
);

  localparam int unsigned NUNITS = MEMORY_KB / UNIT_KB;
  localparam int unsigned NMEM   = (NUNITS > 0) ? NUNITS : 1;
  localparam int unsigned IDX_W  = (NMEM > 1) ? $clog2(NMEM) : 1;
  localparam int unsigned CNT_W  = $clog2(NMEM + 1);
  localparam int unsigned KB_W   = $clog2(MEMORY_KB + 1);
  localparam int unsigned FW     = ffpa_pkg::KB_FIELD_W;
  localparam int unsigned CMP_W  = (KB_W > FW) ? KB_W : FW;

  localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(NUNITS);
  localparam logic [CNT_W-1:0] LAST_CLR = CNT_W'(NMEM - 1);
  localparam logic [KB_W-1:0]  U_KB     = KB_W'(UNIT_KB);

  ffpa_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] iss_q, iss_d;
  logic [KB_W-1:0]  iss_kb_q, iss_kb_d;
  logic [IDX_W-1:0] pk_q, pk_d;
  logic [KB_W-1:0]  pk_kb_q, pk_kb_d;
  logic             proc_vld_q, proc_vld_d;
  logic [FW-1:0]    req_q, req_d;
  logic [FW-1:0]    addr_q, addr_d;
  logic             run_q, run_d;
  logic [IDX_W-1:0] run_idx_q, run_idx_d;
  logic [KB_W-1:0]  run_kb_q, run_kb_d;
  logic [KB_W-1:0]  run_addr_q, run_addr_d;
  logic [IDX_W-1:0] fit_idx_q, fit_idx_d;
  logic [IDX_W-1:0] mark_q, mark_d;
  logic             prev_used_q, prev_used_d;
  ffpa_pkg::out_t   res_q, res_d;
  logic             out_valid_q, out_valid_d;
  ffpa_pkg::out_t   out_data_q, out_data_d;

  ffpa_pkg::map_wr_t map_wr;
  logic [IDX_W-1:0]  used_idx;
  logic [IDX_W-1:0]  start_idx;
  logic              used_rd;
  logic              start_rd;

  logic             issuing;
  logic             scan_done;
  logic             accept;
  logic             resp_load;
  logic [KB_W-1:0]  new_run_kb;
  logic [CMP_W-1:0] req_eff;
  logic             alloc_fit;
  logic             free_match;

  assign accept    = in_valid_i && in_ready_o;
  assign issuing   = (state_q == ffpa_pkg::S_A_SCAN || state_q == ffpa_pkg::S_F_FIND ||
                      state_q == ffpa_pkg::S_F_CLEAR) && (iss_q < N_CNT);
  assign scan_done = !proc_vld_q && (iss_q == N_CNT);
  assign resp_load = (state_q == ffpa_pkg::S_RESP) && (!out_valid_q || out_ready_i);

  assign new_run_kb = run_q ? run_kb_q + U_KB : U_KB;
  assign req_eff    = (req_q == '0) ? CMP_W'(1) : CMP_W'(req_q);
  assign alloc_fit  = proc_vld_q && !used_rd && (CMP_W'(new_run_kb) >= req_eff);
  assign free_match = proc_vld_q && (CMP_W'(pk_kb_q) == CMP_W'(addr_q));

  ffpa_map #(
    .NMEM  (NMEM),
    .IDX_W (IDX_W)
  ) u_map (
    .clk_i       (clk_i),
    .rd_en_i     (issuing),
    .rd_idx_i    (iss_q[IDX_W-1:0]),
    .wr_i        (map_wr),
    .used_idx_i  (used_idx),
    .start_idx_i (start_idx),
    .used_o      (used_rd),
    .start_o     (start_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffpa_pkg::S_CLEAR: begin
        if (iss_q == LAST_CLR) state_d = ffpa_pkg::S_IDLE;
      end
      ffpa_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.op == ffpa_pkg::OP_FREE) ? ffpa_pkg::S_F_FIND
                                                        : ffpa_pkg::S_A_SCAN;
        end
      end
      ffpa_pkg::S_A_SCAN: begin
        if (alloc_fit) state_d = ffpa_pkg::S_A_PEEK;
        else if (scan_done) state_d = ffpa_pkg::S_RESP;
      end
      ffpa_pkg::S_A_PEEK: begin
        state_d = ffpa_pkg::S_A_MARK;
      end
      ffpa_pkg::S_A_MARK: begin
        if (mark_q == fit_idx_q) state_d = ffpa_pkg::S_RESP;
      end
      ffpa_pkg::S_F_FIND: begin
        if (free_match) state_d = start_rd ? ffpa_pkg::S_F_CLEAR : ffpa_pkg::S_RESP;
        else if (scan_done) state_d = ffpa_pkg::S_RESP;
      end
      ffpa_pkg::S_F_CLEAR: begin
        if ((proc_vld_q && start_rd) || scan_done) state_d = ffpa_pkg::S_RESP;
      end
      ffpa_pkg::S_RESP: begin
        if (resp_load) state_d = ffpa_pkg::S_IDLE;
      end
      default: state_d = ffpa_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    iss_d       = iss_q;
    iss_kb_d    = iss_kb_q;
    pk_d        = pk_q;
    pk_kb_d     = pk_kb_q;
    proc_vld_d  = issuing;
    req_d       = req_q;
    addr_d      = addr_q;
    run_d       = run_q;
    run_idx_d   = run_idx_q;
    run_kb_d    = run_kb_q;
    run_addr_d  = run_addr_q;
    fit_idx_d   = fit_idx_q;
    mark_d      = mark_q;
    prev_used_d = prev_used_q;
    res_d       = res_q;
    map_wr      = '0;
    used_idx    = pk_q;
    start_idx   = pk_q;

    if (issuing) begin
      iss_d    = iss_q + CNT_W'(1);
      iss_kb_d = iss_kb_q + U_KB;
      pk_d     = iss_q[IDX_W-1:0];
      pk_kb_d  = iss_kb_q;
    end

    unique case (state_q)
      ffpa_pkg::S_CLEAR: begin
        used_idx        = iss_q[IDX_W-1:0];
        start_idx       = iss_q[IDX_W-1:0];
        map_wr.used_we  = 1'b1;
        map_wr.used_wd  = 1'b0;
        map_wr.start_we = 1'b1;
        map_wr.start_wd = (iss_q == '0);
        iss_d           = iss_q + CNT_W'(1);
      end
      ffpa_pkg::S_IDLE: begin
        if (accept) begin
          iss_d  = '0;
          iss_kb_d = '0;
          run_d  = 1'b0;
          prev_used_d = 1'b0;
          req_d  = in_data_i.request_kb;
          addr_d = in_data_i.release_addr_kb;
        end
      end
      ffpa_pkg::S_A_SCAN: begin
        if (proc_vld_q) begin
          run_d = !used_rd;
          if (!used_rd) begin
            run_kb_d = new_run_kb;
            if (!run_q) begin
              run_idx_d  = pk_q;
              run_addr_d = pk_kb_q;
            end
          end
        end
        if (alloc_fit) begin
          fit_idx_d = pk_q;
        end else if (scan_done) begin
          res_d.status        = ffpa_pkg::ST_NO_FIT;
          res_d.block_addr_kb = '0;
        end
      end
      ffpa_pkg::S_A_PEEK: begin
        if (proc_vld_q && !used_rd) begin
          map_wr.start_we = 1'b1;
          map_wr.start_wd = 1'b1;
        end
        mark_d = run_idx_q;
      end
      ffpa_pkg::S_A_MARK: begin
        used_idx        = mark_q;
        start_idx       = run_idx_q;
        map_wr.used_we  = 1'b1;
        map_wr.used_wd  = 1'b1;
        map_wr.start_we = (mark_q == run_idx_q);
        map_wr.start_wd = 1'b1;
        mark_d          = mark_q + IDX_W'(1);
        if (mark_q == fit_idx_q) begin
          res_d.status        = ffpa_pkg::ST_ALLOCATED;
          res_d.block_addr_kb = FW'(run_addr_q);
        end
      end
      ffpa_pkg::S_F_FIND: begin
        if (proc_vld_q) prev_used_d = used_rd;
        if (free_match && start_rd) begin
          map_wr.used_we  = 1'b1;
          map_wr.used_wd  = 1'b0;
          map_wr.start_we = (pk_q != '0) && !prev_used_q;
          map_wr.start_wd = 1'b0;
        end else if (free_match || scan_done) begin
          res_d.status        = ffpa_pkg::ST_NOT_START;
          res_d.block_addr_kb = '0;
        end
      end
      ffpa_pkg::S_F_CLEAR: begin
        if (proc_vld_q) begin
          if (start_rd) begin
            map_wr.start_we = !used_rd;
            map_wr.start_wd = 1'b0;
          end else begin
            map_wr.used_we = 1'b1;
            map_wr.used_wd = 1'b0;
          end
        end
        res_d.status        = ffpa_pkg::ST_FREED;
        res_d.block_addr_kb = '0;
      end
      ffpa_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (resp_load) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffpa_pkg::S_CLEAR;
      iss_q       <= '0;
      proc_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      proc_vld_q  <= proc_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_kb_q    <= iss_kb_d;
    pk_q        <= pk_d;
    pk_kb_q     <= pk_kb_d;
    req_q       <= req_d;
    addr_q      <= addr_d;
    run_q       <= run_d;
    run_idx_q   <= run_idx_d;
    run_kb_q    <= run_kb_d;
    run_addr_q  <= run_addr_d;
    fit_idx_q   <= fit_idx_d;
    mark_q      <= mark_d;
    prev_used_q <= prev_used_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
  end

  assign in_ready_o  = (state_q == ffpa_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `FFPA_ASSERT_ALWAYS(a_addr_zero, out_valid_o && (out_data_o.status != ffpa_pkg::ST_ALLOCATED) |-> (out_data_o.block_addr_kb == '0), "address set on a non-allocate beat")
  `FFPA_ASSERT(a_clear_once, (state_q != ffpa_pkg::S_CLEAR) |=> (state_q != ffpa_pkg::S_CLEAR), "clearing pass re-entered")
  `FFPA_ASSERT(a_accept_scan, accept |=> (state_q == ffpa_pkg::S_A_SCAN || state_q == ffpa_pkg::S_F_FIND), "accepted beat did not start a sweep")
  `FFPA_ASSERT(a_proc_range, proc_vld_q |-> (CNT_W'(pk_q) < N_CNT), "processed unit beyond the region")
  `FFPA_ASSERT(a_mark_span, (state_q == ffpa_pkg::S_A_MARK) |-> (mark_q >= run_idx_q && mark_q <= fit_idx_q), "marking outside the chosen run")

endmodule

// ===== rtl/ffpa_map.sv =====
// Unit map store: one used bit and one block-start bit per unit, each a
// single-port-write memory with a registered read. Depends on ffpa_pkg.
module ffpa_map #(
  parameter int unsigned NMEM  = 160,
  parameter int unsigned IDX_W = 8
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  input  ffpa_pkg::map_wr_t wr_i,
  input  logic [IDX_W-1:0]  used_idx_i,
  input  logic [IDX_W-1:0]  start_idx_i,
  output logic              used_o,
  output logic              start_o
);

  logic used_mem  [NMEM];
  logic start_mem [NMEM];
  logic used_q;
  logic start_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.used_we) begin
      used_mem[used_idx_i] <= wr_i.used_wd;
    end
    if (wr_i.start_we) begin
      start_mem[start_idx_i] <= wr_i.start_wd;
    end
    if (rd_en_i) begin
      used_q  <= used_mem[rd_idx_i];
      start_q <= start_mem[rd_idx_i];
    end
  end

  assign used_o  = used_q;
  assign start_o = start_q;

endmodule
